/* rtl/core/fpsr_pkg.sv */
// ============================================================================
// fpsr_pkg
// Shared constants and types of the five-point stencil residual block.
// ============================================================================
`default_nettype none

package fpsr_pkg;

    // Defaults of the top-level parameters.
    localparam int MAX_COLS_DEFAULT    = 1024;
    localparam int SAMPLE_BITS_DEFAULT = 32;

    // Fixed field widths.
    localparam int ROW_W = 16;
    localparam int COL_W = 10;
    localparam int GC_W  = 11;
    localparam int GR_W  = 16;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register indexes (paddr bit 2).
    localparam logic REG_GRID_COLUMNS = 1'b0;
    localparam logic REG_GRID_ROWS    = 1'b1;

    localparam logic [GC_W-1:0] GRID_COLUMNS_RESET = GC_W'(1024);
    localparam logic [GR_W-1:0] GRID_ROWS_RESET    = GR_W'(1024);

    // Output queue.
    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    // Position and end-of-frame flag of one emitted cell.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_tag;

    localparam int TAG_W = $bits(t_tag);

    // Which of the two possible results of one input item are written.
    typedef struct packed {
        logic first;
        logic second;
    } t_push;

endpackage

`default_nettype wire

/* rtl/core/five_point_stencil_residual.sv */
// ============================================================================
// five_point_stencil_residual
// Five-point Laplacian residual over a raster-order stream of grid samples.
// ============================================================================
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+----------------------------------
//  sample   | in        | i_valid / o_stall  | i_sample
//  result   | out       | o_valid / i_stall  | o_result, o_out_row, o_out_col,
//           |           |                    | o_frame_last
//  config   | in        | APB psel/penable   | paddr, pwdata, prdata
//
//  One sample is accepted per cycle unless o_stall holds it. A result
//  passes through the input stage register and then the result queue.
//  The line buffer is read every cycle at the column of the next sample, so
//  a sample never waits for memory; a same-column write is forwarded.
//  Past row 0, last-row samples give two results and the output sets the pace.
//  Reset clears counters and the queue; the line buffer holds no reset.
//  A configuration write restarts the frame at row 0, column 0.
// ============================================================================
`default_nettype none

module five_point_stencil_residual #(
    parameter int MAX_COLS    = fpsr_pkg::MAX_COLS_DEFAULT,
    parameter int SAMPLE_BITS = fpsr_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [fpsr_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [fpsr_pkg::PDATA_W-1:0]      pwdata,
    output logic      [fpsr_pkg::PDATA_W-1:0]      prdata,
    output logic                                   pready,
    // sample channel
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_sample,
    // result channel
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic signed [SAMPLE_BITS:0]            o_result,
    output logic [fpsr_pkg::ROW_W-1:0]             o_out_row,
    output logic [fpsr_pkg::COL_W-1:0]             o_out_col,
    output logic                                   o_frame_last
);

    localparam int SB     = SAMPLE_BITS;
    localparam int ADDR_W = $clog2(MAX_COLS);
    localparam int CNT_W  = $clog2(MAX_COLS + 1);
    localparam int CMP_W  = (CNT_W > fpsr_pkg::GC_W) ? CNT_W : fpsr_pkg::GC_W;
    localparam int MEM_W  = 2 * SB;
    localparam int RES_W  = SB + 1;
    localparam int ITEM_W = RES_W + fpsr_pkg::TAG_W;
    localparam int ROW_W  = fpsr_pkg::ROW_W;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [fpsr_pkg::GC_W-1:0] r_grid_columns;
    logic [fpsr_pkg::GR_W-1:0] r_grid_rows;
    logic                      cfg_wr;
    logic                      reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_wr    = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns <= fpsr_pkg::GRID_COLUMNS_RESET;
            r_grid_rows    <= fpsr_pkg::GRID_ROWS_RESET;
        end else if (cfg_wr) begin
            unique case (reg_index)
                fpsr_pkg::REG_GRID_COLUMNS: r_grid_columns <= pwdata[fpsr_pkg::GC_W-1:0];
                fpsr_pkg::REG_GRID_ROWS:    r_grid_rows    <= pwdata[fpsr_pkg::GR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            fpsr_pkg::REG_GRID_COLUMNS: prdata = fpsr_pkg::PDATA_W'(r_grid_columns);
            fpsr_pkg::REG_GRID_ROWS:    prdata = fpsr_pkg::PDATA_W'(r_grid_rows);
            default:                    prdata = '0;
        endcase
    end

    // Effective frame size: columns clamp to 1..MAX_COLS, zero rows act as one.
    logic [CNT_W-1:0] eff_cols;
    logic [ROW_W-1:0] eff_rows;

    always_comb begin
        if (r_grid_columns == '0) begin
            eff_cols = CNT_W'(1);
        end else if (CMP_W'(r_grid_columns) > CMP_W'(MAX_COLS)) begin
            eff_cols = CNT_W'(MAX_COLS);
        end else begin
            eff_cols = CNT_W'(r_grid_columns);
        end
        eff_rows = (r_grid_rows == '0) ? ROW_W'(1) : r_grid_rows;
    end

    // ------------------------------------------------------------------------
    // Position counters and line buffer access
    // ------------------------------------------------------------------------
    logic [ADDR_W-1:0] r_col;
    logic [ROW_W-1:0]  r_row;
    logic [SB-1:0]     r_left;
    logic [CNT_W-1:0]  col_plus1;
    logic [ROW_W:0]    row_plus1;
    logic              last_col;
    logic              last_row;
    logic [ADDR_W-1:0] n_col;
    logic [ROW_W-1:0]  n_row;
    logic              accept;

    logic [fpsr_pkg::QCNT_W-1:0] q_count;
    logic [1:0]                  s1_n;

    assign col_plus1 = CNT_W'(r_col) + CNT_W'(1);
    assign row_plus1 = (ROW_W+1)'(r_row) + (ROW_W+1)'(1);
    assign last_col  = (col_plus1 == eff_cols);
    assign last_row  = (row_plus1 == (ROW_W+1)'(eff_rows));

    always_comb begin
        n_col = last_col ? '0 : ADDR_W'(col_plus1);
        n_row = r_row;
        if (last_col) begin
            n_row = last_row ? '0 : row_plus1[ROW_W-1:0];
        end
    end

    // Room must remain for the results in the input stage and for the next item.
    assign o_stall = !i_rst_n
        || ((4'(q_count) + 4'(s1_n) + 4'd2) > 4'(fpsr_pkg::Q_DEPTH));
    assign accept  = i_valid && !o_stall;

    // Line buffer word: {two rows back, one row back}.
    logic [ADDR_W-1:0] rd_addr0;
    logic [ADDR_W-1:0] rd_addr1;
    logic [MEM_W-1:0]  rd_data0;
    logic [MEM_W-1:0]  rd_data1;
    logic [MEM_W-1:0]  wr_data;
    logic              r_fwd0;
    logic              r_fwd1;
    logic [MEM_W-1:0]  r_fwd_data;
    logic [MEM_W-1:0]  word_c;
    logic [SB-1:0]     center;
    logic [SB-1:0]     up;
    logic [SB-1:0]     right;

    // Read at the column the next sample will have.
    always_comb begin
        if (cfg_wr) begin
            rd_addr0 = '0;
        end else if (accept) begin
            rd_addr0 = n_col;
        end else begin
            rd_addr0 = r_col;
        end
        rd_addr1 = (rd_addr0 == ADDR_W'(MAX_COLS - 1)) ? '0 : rd_addr0 + ADDR_W'(1);
    end

    assign word_c  = r_fwd0 ? r_fwd_data : rd_data0;
    assign center  = word_c[SB-1:0];
    assign up      = word_c[MEM_W-1:SB];
    assign right   = r_fwd1 ? r_fwd_data[SB-1:0] : rd_data1[SB-1:0];
    assign wr_data = {center, i_sample};

    fpsr_line_mem #(
        .DEPTH  (MAX_COLS),
        .ADDR_W (ADDR_W),
        .DATA_W (MEM_W)
    ) u_line_mem (
        .i_clk    (i_clk),
        .i_we     (accept),
        .i_waddr  (r_col),
        .i_wdata  (wr_data),
        .i_raddr0 (rd_addr0),
        .i_raddr1 (rd_addr1),
        .o_rdata0 (rd_data0),
        .o_rdata1 (rd_data1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
            r_fwd0 <= 1'b0;
            r_fwd1 <= 1'b0;
        end else begin
            r_fwd0 <= accept && (rd_addr0 == r_col);
            r_fwd1 <= accept && (rd_addr1 == r_col);
            if (cfg_wr) begin
                r_col  <= '0;
                r_row  <= '0;
                r_left <= '0;
            end else if (accept) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_left <= center;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= wr_data;
    end

    // ------------------------------------------------------------------------
    // Input stage register
    // ------------------------------------------------------------------------
    logic                  r_s1_valid;
    logic signed [SB-1:0]  r_s1_x;
    logic signed [SB-1:0]  r_s1_center;
    logic signed [SB-1:0]  r_s1_up;
    logic signed [SB-1:0]  r_s1_left;
    logic signed [SB-1:0]  r_s1_right;
    logic [ROW_W-1:0]      r_s1_row;
    logic [ADDR_W-1:0]     r_s1_col;
    logic                  r_s1_emit_prev;
    logic                  r_s1_border;
    logic                  r_s1_emit_own;
    logic                  r_s1_last_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_x         <= i_sample;
            r_s1_center    <= center;
            r_s1_up        <= up;
            r_s1_left      <= r_left;
            r_s1_right     <= right;
            r_s1_row       <= r_row;
            r_s1_col       <= r_col;
            r_s1_emit_prev <= (r_row != '0);
            r_s1_border    <= (r_row == ROW_W'(1)) || (r_col == '0) || last_col;
            r_s1_emit_own  <= last_row;
            r_s1_last_col  <= last_col;
        end
    end

    // ------------------------------------------------------------------------
    // Residual: center minus the floor quarter of the neighbor sum
    // ------------------------------------------------------------------------
    logic signed [SB+1:0]  nb_sum;
    logic signed [SB-1:0]  quarter;
    logic signed [RES_W-1:0] residual;
    logic [RES_W-1:0]      val0;
    logic [RES_W-1:0]      val1;
    fpsr_pkg::t_tag        tag0;
    fpsr_pkg::t_tag        tag1;
    fpsr_pkg::t_push       push;

    always_comb begin
        nb_sum = (SB+2)'(r_s1_up) + (SB+2)'(r_s1_x)
               + (SB+2)'(r_s1_left) + (SB+2)'(r_s1_right);
        // Dropping the two low bits of a two's complement sum rounds down.
        quarter  = nb_sum[SB+1:2];
        residual = RES_W'(r_s1_center) - RES_W'(quarter);

        val0 = r_s1_border ? RES_W'(r_s1_center) : residual;
        val1 = RES_W'(r_s1_x);

        tag0.row  = r_s1_row - ROW_W'(1);
        tag0.col  = fpsr_pkg::COL_W'(r_s1_col);
        tag0.last = 1'b0;
        tag1.row  = r_s1_row;
        tag1.col  = fpsr_pkg::COL_W'(r_s1_col);
        tag1.last = r_s1_last_col;

        push.first  = r_s1_valid && r_s1_emit_prev;
        push.second = r_s1_valid && r_s1_emit_own;
    end

    assign s1_n = 2'(push.first) + 2'(push.second);

    // ------------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------------
    logic [ITEM_W-1:0] q_data;
    fpsr_pkg::t_tag    q_tag;

    fpsr_out_queue #(
        .DATA_W (ITEM_W)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data0 ({val0, tag0}),
        .i_data1 ({val1, tag1}),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign o_result     = q_data[ITEM_W-1:fpsr_pkg::TAG_W];
    assign q_tag        = q_data[fpsr_pkg::TAG_W-1:0];
    assign o_out_row    = q_tag.row;
    assign o_out_col    = q_tag.col;
    assign o_frame_last = q_tag.last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> ((4'(q_count) + 4'(s1_n)) <= 4'(fpsr_pkg::Q_DEPTH)))
        else $error("result queue would overflow");

    a_fwd_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fwd0 || r_fwd1) |-> $past(i_valid && !o_stall))
        else $error("line buffer forwarding without a preceding write");

    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (CNT_W'(r_col) < eff_cols))
        else $error("column counter outside the frame");

endmodule

`default_nettype wire

/* rtl/core/fpsr_line_mem.sv */
// ============================================================================
// fpsr_line_mem
// Line buffer memory: one write port, two registered read ports.
// ============================================================================
`default_nettype none

module fpsr_line_mem #(
    parameter int DEPTH  = fpsr_pkg::MAX_COLS_DEFAULT,
    parameter int ADDR_W = $clog2(fpsr_pkg::MAX_COLS_DEFAULT),
    parameter int DATA_W = 2 * fpsr_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr0,
    input  wire logic [ADDR_W-1:0] i_raddr1,
    output logic      [DATA_W-1:0] o_rdata0,
    output logic      [DATA_W-1:0] o_rdata1
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Reads return the contents from before a write at the same edge.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

`default_nettype wire

/* rtl/core/fpsr_out_queue.sv */
// ============================================================================
// fpsr_out_queue
// Four-entry result queue that takes up to two results per cycle.
// ============================================================================
`default_nettype none

module fpsr_out_queue #(
    parameter int DATA_W = fpsr_pkg::SAMPLE_BITS_DEFAULT + 1 + fpsr_pkg::TAG_W
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire fpsr_pkg::t_push             i_push,
    input  wire logic [DATA_W-1:0]           i_data0,
    input  wire logic [DATA_W-1:0]           i_data1,
    input  wire logic                        i_stall,
    output logic                             o_valid,
    output logic [DATA_W-1:0]                o_data,
    output logic [fpsr_pkg::QCNT_W-1:0]      o_count
);

    logic [DATA_W-1:0]              r_entry [fpsr_pkg::Q_DEPTH];
    logic [fpsr_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [fpsr_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [fpsr_pkg::QCNT_W-1:0]    r_count;
    logic [fpsr_pkg::QPTR_W-1:0]    second_ptr;
    logic [fpsr_pkg::QCNT_W-1:0]    push_n;
    logic                           pop;

    assign pop        = o_valid && !i_stall;
    assign push_n     = fpsr_pkg::QCNT_W'(i_push.first) + fpsr_pkg::QCNT_W'(i_push.second);
    assign second_ptr = r_wr_ptr + fpsr_pkg::QPTR_W'(i_push.first);

    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_entry[r_wr_ptr] <= i_data0;
        end
        if (i_push.second) begin
            r_entry[second_ptr] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + fpsr_pkg::QPTR_W'(push_n);
            r_rd_ptr <= r_rd_ptr + fpsr_pkg::QPTR_W'(pop);
            r_count  <= r_count + push_n - fpsr_pkg::QCNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

/* sim/five_point_stencil_residual_tb.sv */
// ----------------------------------------------------------------------------
// five_point_stencil_residual_tb
// Streams grid samples through the stencil block under random sender bursts and
// receiver stalls. A behavioral copy of the line buffers predicts every result,
// including the interior residual, the border pass-through and the extra cell
// of the last row. Results are compared field by field in arrival order.
// Grid geometry is reprogrammed between phases, often partway through a frame.
// ----------------------------------------------------------------------------
module five_point_stencil_residual_tb;

    localparam int SAMPLE_W    = 32;
    localparam int COLS_LIMIT  = 1024;
    localparam int RANDOM_ITEMS = 330;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 8;

    localparam int ROW_W   = fpsr_pkg::ROW_W;
    localparam int COL_W   = fpsr_pkg::COL_W;
    localparam int GC_W    = fpsr_pkg::GC_W;
    localparam int GR_W    = fpsr_pkg::GR_W;
    localparam int PADDR_W = fpsr_pkg::PADDR_W;
    localparam int PDATA_W = fpsr_pkg::PDATA_W;

    typedef struct {
        logic signed [SAMPLE_W:0] value;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic                     last;
    } t_residual;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [SAMPLE_W:0] o_result;
    logic [ROW_W-1:0] o_out_row;
    logic [COL_W-1:0] o_out_col;
    logic o_frame_last;

    five_point_stencil_residual dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall), .i_sample(i_sample),
        .o_valid(o_valid), .i_stall(i_stall), .o_result(o_result),
        .o_out_row(o_out_row), .o_out_col(o_out_col), .o_frame_last(o_frame_last)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state: geometry, raster position and the two previous rows.
    logic [GC_W-1:0] grid_cols_reg = fpsr_pkg::GRID_COLUMNS_RESET;
    logic [GR_W-1:0] grid_rows_reg = fpsr_pkg::GRID_ROWS_RESET;
    int unsigned row_pos = 0;
    int unsigned col_pos = 0;
    logic [SAMPLE_W-1:0] left_val = '0;
    logic [SAMPLE_W-1:0] prev_row [COLS_LIMIT];
    logic [SAMPLE_W-1:0] prev_prev_row [COLS_LIMIT];

    logic [SAMPLE_W-1:0] pending_samples [$];
    t_residual awaited_residuals [$];
    int error_count = 0;
    int cycle_count = 0;

    bit sender_idles = 1'b1;
    bit receiver_stalls = 1'b1;
    int burst_left = 0;
    int gap_left = 0;
    int stall_run = 0;
    int stall_hold = 0;

    function automatic int unsigned eff_columns();
        if (grid_cols_reg == '0) return 1;
        if (grid_cols_reg > COLS_LIMIT) return COLS_LIMIT;
        return 32'(grid_cols_reg);
    endfunction

    function automatic int unsigned eff_rows();
        return (grid_rows_reg == '0) ? 1 : 32'(grid_rows_reg);
    endfunction

    // Computes the results caused by one accepted sample and advances the raster.
    function automatic void predict_residuals(logic [SAMPLE_W-1:0] x);
        int unsigned cols;
        int unsigned rows;
        int unsigned r;
        int unsigned c;
        logic [SAMPLE_W-1:0] center;
        logic [SAMPLE_W-1:0] up;
        logic [SAMPLE_W-1:0] right;
        longint neighbor_sum;
        longint diff;
        t_residual res;
        cols = eff_columns();
        rows = eff_rows();
        r = row_pos;
        c = col_pos;
        center = prev_row[c];
        up = prev_prev_row[c];
        right = (c + 1 < cols) ? prev_row[c + 1] : '0;
        if (r >= 1) begin
            res.row = ROW_W'(r - 1);
            res.col = COL_W'(c);
            res.last = 1'b0;
            if (r == 1 || c == 0 || c + 1 == cols) begin
                res.value = $signed(center);
            end else begin
                neighbor_sum = longint'($signed(up)) + longint'($signed(x))
                             + longint'($signed(left_val)) + longint'($signed(right));
                // The arithmetic shift rounds the quarter toward minus infinity.
                diff = longint'($signed(center)) - (neighbor_sum >>> 2);
                res.value = diff[SAMPLE_W:0];
            end
            awaited_residuals.push_back(res);
        end
        left_val = center;
        prev_prev_row[c] = center;
        prev_row[c] = x;
        if (r + 1 == rows) begin
            res.value = $signed(x);
            res.row = ROW_W'(r);
            res.col = COL_W'(c);
            res.last = (c + 1 == cols);
            awaited_residuals.push_back(res);
        end
        c++;
        if (c >= cols) begin
            c = 0;
            r++;
            if (r >= rows) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 9);
        if (!sender_idles || k < 5) return 0;
        if (k < 8) return $urandom_range(1, 3);
        return $urandom_range(4, 12);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int k;
        logic [SAMPLE_W-1:0] s;
        k = $urandom_range(0, 9);
        case (k)
            0: begin
                s = 32'h8000_0000;
            end
            1: begin
                s = 32'h7FFF_FFFF;
            end
            2, 3: begin
                // Small values around zero exercise the rounding of negative sums.
                s = SAMPLE_W'($urandom_range(0, 16)) - 32'd8;
            end
            default: begin
                s = $urandom;
            end
        endcase
        return s;
    endfunction

    function automatic void compare_field(string name, logic signed [63:0] want,
                                          logic signed [63:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Sender: one transaction per handshake, bursts separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_residuals(i_sample);
                void'(pending_samples.pop_front());
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    i_valid <= 1'b1;
                    i_sample <= pending_samples[0];
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = pick_gap();
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result transaction and stalls in runs of its own.
    always @(posedge i_clk) begin
        t_residual want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (awaited_residuals.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, got %0d at row %0d col %0d",
                             $time, o_result, o_out_row, o_out_col);
                end else begin
                    want = awaited_residuals.pop_front();
                    compare_field("result", 64'(want.value), 64'(o_result));
                    compare_field("out_row", 64'(want.row), 64'(o_out_row));
                    compare_field("out_col", 64'(want.col), 64'(o_out_col));
                    compare_field("frame_last", 64'(want.last), 64'(o_frame_last));
                end
            end
            if (!receiver_stalls) begin
                i_stall <= 1'b0;
            end else if (stall_hold > 0) begin
                stall_hold--;
                i_stall <= 1'b1;
            end else if (stall_run > 0) begin
                stall_run--;
                i_stall <= 1'b0;
            end else begin
                stall_run = $urandom_range(0, 12);
                stall_hold = $urandom_range(1, 6);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic read_reg(input logic reg_idx, input logic [PDATA_W-1:0] want);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {reg_idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            error_count++;
            $display("%0t: register %0d readback, expected %0d, got %0d",
                     $time, reg_idx, want, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Any write restarts the frame at row 0, column 0.
    task automatic write_reg(input logic reg_idx, input logic [PDATA_W-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_idx == fpsr_pkg::REG_GRID_COLUMNS) grid_cols_reg = data[GC_W-1:0];
        else grid_rows_reg = data[GR_W-1:0];
        row_pos = 0;
        col_pos = 0;
        left_val = '0;
        read_reg(reg_idx, (reg_idx == fpsr_pkg::REG_GRID_COLUMNS) ? PDATA_W'(grid_cols_reg)
                                                                    : PDATA_W'(grid_rows_reg));
    endtask

    task automatic configure(input logic [GC_W-1:0] cols, input logic [GR_W-1:0] rows,
                             input bit set_cols, input bit set_rows);
        logic [PDATA_W-1:0] data;
        if (set_cols) begin
            // Unused upper bits of the write data are sometimes set.
            data = ($urandom_range(0, 3) == 0) ? PDATA_W'($urandom) : '0;
            data[GC_W-1:0] = cols;
            write_reg(fpsr_pkg::REG_GRID_COLUMNS, data);
        end
        if (set_rows) begin
            data = ($urandom_range(0, 3) == 0) ? PDATA_W'($urandom) : '0;
            data[GR_W-1:0] = rows;
            write_reg(fpsr_pkg::REG_GRID_ROWS, data);
        end
    endtask

    // Rows of a frame may emit nothing, so the drain waits on past the last result.
    task automatic drain();
        while (pending_samples.size() != 0 || i_valid || awaited_residuals.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_random(input int count);
        repeat (count) pending_samples.push_back(pick_sample());
    endtask

    initial begin
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        logic [GC_W-1:0] cols;
        logic [GR_W-1:0] rows;
        int unsigned frame;
        int count;
        int random_sent;
        int k;
        random_sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_reg(fpsr_pkg::REG_GRID_COLUMNS, PDATA_W'(fpsr_pkg::GRID_COLUMNS_RESET));
        read_reg(fpsr_pkg::REG_GRID_ROWS, PDATA_W'(fpsr_pkg::GRID_ROWS_RESET));

        // Reset geometry: the first row of a tall grid emits nothing.
        push_random(4);
        drain();

        // Single interior cell against extreme neighbors, both signs.
        configure(GC_W'(3), GR_W'(3), 1'b1, 1'b1);
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
        for (int i = 0; i < 9; i++) pending_samples.push_back((i == 4) ? hi : lo);
        drain();
        for (int i = 0; i < 9; i++) pending_samples.push_back((i == 4) ? lo : hi);
        drain();

        // Zero columns and zero rows act as a single cell per frame.
        configure('0, '0, 1'b1, 1'b1);
        push_random(3);
        drain();

        while (random_sent < RANDOM_ITEMS) begin
            sender_idles = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            k = $urandom_range(0, 19);
            if (k < 14) cols = GC_W'($urandom_range(1, 8));
            else if (k < 16) cols = '0;
            else if (k < 18) cols = GC_W'($urandom_range(9, 40));
            else if (k < 19) cols = GC_W'(COLS_LIMIT);
            else cols = GC_W'($urandom_range(COLS_LIMIT + 1, 2047));
            k = $urandom_range(0, 19);
            if (k < 15) rows = GR_W'($urandom_range(1, 6));
            else if (k < 17) rows = '0;
            else if (k < 18) rows = 16'hFFFF;
            else rows = GR_W'($urandom_range(7, 65534));
            k = $urandom_range(0, 5);
            configure(cols, rows, k != 1, k != 0);
            frame = eff_columns() * eff_rows();
            // Phases often stop partway through a frame before the next write.
            if (frame <= 60) begin
                count = frame * $urandom_range(1, 3);
                if ($urandom_range(0, 1) == 1) count += $urandom_range(0, frame - 1);
                if (count > 150) count = 150;
            end else begin
                count = $urandom_range(20, 150);
            end
            push_random(count);
            random_sent += count;
            drain();
        end

        // Widest row, clamped from the largest column setting, reaches the last column.
        sender_idles = 1'b1;
        receiver_stalls = 1'b1;
        configure(11'h7FF, GR_W'(1), 1'b1, 1'b1);
        push_random(COLS_LIMIT + 6);
        drain();

        // Tallest grid with one interior column.
        configure(GC_W'(3), 16'hFFFF, 1'b1, 1'b1);
        push_random(15);
        drain();

        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
